@@ hw/rtl/touch_sample_group_filter_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Touch sample group filter assertion macros
// Shared concurrent assertion forms for the filter unit.
// ---------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_GROUP_FILTER_UNIT_DEFINES_SVH
`define TOUCH_SAMPLE_GROUP_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSGF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tsgf assertion failed");

// Next-cycle implication, disabled during reset.
`define TSGF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tsgf assertion failed");

`endif

@@ hw/rtl/tsgf_pkg.sv @@
// ---------------------------------------------------------------------------
// Touch sample group filter package
// Widths, constants, result codes and the job record passed front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package tsgf_pkg;

  localparam int unsigned ADC_BITS   = 12;
  localparam int unsigned THRESH_W   = 12;
  localparam int unsigned SUM_W      = ADC_BITS + 2;
  localparam int unsigned RECIP_SH   = 2 * (SUM_W / 2) + 1;
  localparam int unsigned RECIP      = ((1 << RECIP_SH) + 1) / 3;
  localparam int unsigned PROD_W     = SUM_W + RECIP_SH;
  localparam int unsigned CMP_W      = (ADC_BITS > THRESH_W) ? ADC_BITS : THRESH_W;
  localparam int unsigned NUM_GROUPS = 3;
  localparam int unsigned GROUP_LEN  = 3;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(300);

  typedef logic [ADC_BITS-1:0] sample_t;
  typedef logic [SUM_W-1:0]    gsum_t;
  typedef logic [THRESH_W-1:0] thresh_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SCATTER = 2'd1,
    ST_RELEASE = 2'd2
  } status_e;

  typedef struct packed {
    logic                       is_rel;
    gsum_t [NUM_GROUPS-1:0]     sum_x;
    gsum_t [NUM_GROUPS-1:0]     sum_y;
  } job_t;

endpackage

`default_nettype wire

@@ hw/rtl/tsgf_front.sv @@
// ---------------------------------------------------------------------------
// Touch sample group filter front end
// Accepts samples, builds per-group sums and issues capture or release jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module tsgf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              full_i,
  input  wire tsgf_pkg::sample_t sample_x_i,
  input  wire tsgf_pkg::sample_t sample_y_i,
  input  wire logic              pen_up_i,
  output logic                   push_o,
  output tsgf_pkg::job_t         job_o
);
  import tsgf_pkg::*;

  localparam logic [1:0] LAST_POS = 2'(GROUP_LEN - 1);
  localparam logic [1:0] LAST_GRP = 2'(NUM_GROUPS - 1);

  logic [1:0] pos_q, pos_d;
  logic [1:0] grp_q, grp_d;
  gsum_t      acc_x_q, acc_x_d;
  gsum_t      acc_y_q, acc_y_d;
  gsum_t      gx_q [2];
  gsum_t      gy_q [2];
  gsum_t      sum_x_now;
  gsum_t      sum_y_now;
  logic       accept;
  logic       last;

  assign accept    = start_i && !full_i;
  assign last      = (grp_q == LAST_GRP) && (pos_q == LAST_POS);
  assign sum_x_now = (pos_q == 2'd0) ? SUM_W'(sample_x_i) : acc_x_q + SUM_W'(sample_x_i);
  assign sum_y_now = (pos_q == 2'd0) ? SUM_W'(sample_y_i) : acc_y_q + SUM_W'(sample_y_i);
  assign push_o    = accept && (last || pen_up_i);

  always_comb begin
    job_o.is_rel   = !last;
    job_o.sum_x[0] = gx_q[0];
    job_o.sum_x[1] = gx_q[1];
    job_o.sum_x[2] = sum_x_now;
    job_o.sum_y[0] = gy_q[0];
    job_o.sum_y[1] = gy_q[1];
    job_o.sum_y[2] = sum_y_now;
  end

  always_comb begin
    pos_d   = pos_q;
    grp_d   = grp_q;
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    if (accept) begin
      acc_x_d = sum_x_now;
      acc_y_d = sum_y_now;
      if (push_o) begin
        pos_d = 2'd0;
        grp_d = 2'd0;
      end else if (pos_q == LAST_POS) begin
        pos_d = 2'd0;
        grp_d = grp_q + 2'd1;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
      grp_q <= 2'd0;
    end else begin
      pos_q <= pos_d;
      grp_q <= grp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_x_q <= acc_x_d;
    acc_y_q <= acc_y_d;
    if (accept && !push_o && (pos_q == LAST_POS)) begin
      gx_q[grp_q[0]] <= sum_x_now;
      gy_q[grp_q[0]] <= sum_y_now;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tsgf_fifo.sv @@
// ---------------------------------------------------------------------------
// Touch sample group filter job queue
// Two-entry queue decoupling the front end from the filter back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tsgf_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tsgf_pkg::job_t job_i,
  input  wire logic           pop_i,
  output tsgf_pkg::job_t      job_o,
  output logic                empty_o,
  output logic                full_o,
  output logic [1:0]          count_o
);
  import tsgf_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign count_o = cnt_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tsgf_back.sv @@
// ---------------------------------------------------------------------------
// Touch sample group filter back end
// Three-stage pipe: group means, spreads, then reject test and pair average.
// ---------------------------------------------------------------------------
`default_nettype none

module tsgf_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire tsgf_pkg::job_t     job_i,
  input  wire tsgf_pkg::thresh_t  thresh_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output tsgf_pkg::sample_t       point_x_o,
  output tsgf_pkg::sample_t       point_y_o
);
  import tsgf_pkg::*;

  typedef sample_t [NUM_GROUPS-1:0] means_t;

  typedef struct packed {
    logic    rej;
    sample_t val;
  } axis_t;

  function automatic sample_t mean3(input gsum_t s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s) * PROD_W'(RECIP);
    return prod[RECIP_SH +: ADC_BITS];
  endfunction

  function automatic sample_t absdiff(input sample_t a, input sample_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic axis_t pick(input means_t m, input means_t d, input thresh_t thr);
    axis_t                r;
    logic [CMP_W-1:0]     t;
    logic [ADC_BITS:0]    s;
    t = CMP_W'(thr);
    r.rej = (CMP_W'(d[0]) > t) && (CMP_W'(d[1]) > t) && (CMP_W'(d[2]) > t);
    if (d[0] < d[1]) begin
      s = (d[2] < d[0]) ? ({1'b0, m[0]} + {1'b0, m[2]}) : ({1'b0, m[0]} + {1'b0, m[1]});
    end else if (d[2] < d[1]) begin
      s = {1'b0, m[0]} + {1'b0, m[2]};
    end else begin
      s = {1'b0, m[1]} + {1'b0, m[2]};
    end
    r.val = s[ADC_BITS:1];
    return r;
  endfunction

  logic    v1_q, v2_q, done_q;
  logic    rel1_q, rel2_q;
  means_t  mx1_q, my1_q, mx2_q, my2_q, dx2_q, dy2_q;
  means_t  mx1_d, my1_d;
  axis_t   ax, ay;
  status_e status_q;
  sample_t px_q, py_q;

  assign pop_o = !empty_i;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      mx1_d[g] = mean3(job_i.sum_x[g]);
      my1_d[g] = mean3(job_i.sum_y[g]);
    end
  end

  assign ax = pick(mx2_q, dx2_q, thresh_i);
  assign ay = pick(my2_q, dy2_q, thresh_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= pop_o;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rel1_q <= job_i.is_rel;
    mx1_q  <= mx1_d;
    my1_q  <= my1_d;

    rel2_q   <= rel1_q;
    mx2_q    <= mx1_q;
    my2_q    <= my1_q;
    dx2_q[0] <= absdiff(mx1_q[0], mx1_q[1]);
    dx2_q[1] <= absdiff(mx1_q[1], mx1_q[2]);
    dx2_q[2] <= absdiff(mx1_q[2], mx1_q[0]);
    dy2_q[0] <= absdiff(my1_q[0], my1_q[1]);
    dy2_q[1] <= absdiff(my1_q[1], my1_q[2]);
    dy2_q[2] <= absdiff(my1_q[2], my1_q[0]);

    if (rel2_q) begin
      status_q <= ST_RELEASE;
      px_q     <= '0;
      py_q     <= '0;
    end else if (ax.rej || ay.rej) begin
      status_q <= ST_SCATTER;
      px_q     <= '0;
      py_q     <= '0;
    end else begin
      status_q <= ST_OK;
      px_q     <= ax.val;
      py_q     <= ay.val;
    end
  end

  assign done_o    = done_q;
  assign status_o  = status_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;

endmodule

`default_nettype wire

@@ hw/rtl/touch_sample_group_filter_unit.sv @@
// Result: done_o rises once the job of the ninth sample, or of a pen-up sample that ends
// a capture early, has passed the job queue and the three back-end stages.
// Throughput: one sample per cycle; the three-stage back end drains the job
// queue every cycle, so busy_o stays low and the receiver cannot stall.
// Reset: rst_ni clears the sample position, the queue and the pipe valids;
// the threshold returns to 300.
// ---------------------------------------------------------------------------
// Touch sample group filter unit
// Nine-sample, three-group touch filter with scatter reject and release.
// ---------------------------------------------------------------------------
`default_nettype none

`include "touch_sample_group_filter_unit_defines.svh"

module touch_sample_group_filter_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire tsgf_pkg::sample_t   sample_x_i,
  input  wire tsgf_pkg::sample_t   sample_y_i,
  input  wire logic                pen_up_i,
  input  wire logic                cfg_we_i,
  input  wire tsgf_pkg::thresh_t   cfg_wdata_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output tsgf_pkg::sample_t        point_x_o,
  output tsgf_pkg::sample_t        point_y_o
);
  import tsgf_pkg::*;

  thresh_t    thresh_q;
  logic       push, pop, empty, full;
  logic [1:0] fifo_count;
  job_t       job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  assign busy_o = full;

  tsgf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .full_i     (full),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .pen_up_i   (pen_up_i),
    .push_o     (push),
    .job_o      (job_in)
  );

  tsgf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty),
    .full_o  (full),
    .count_o (fifo_count)
  );

  tsgf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .job_i     (job_out),
    .thresh_i  (thresh_q),
    .pop_o     (pop),
    .done_o    (done_o),
    .status_o  (status_o),
    .point_x_o (point_x_o),
    .point_y_o (point_y_o)
  );

  `TSGF_ASSERT_IMPLIES(a_point_zero_unless_ok, clk_i, rst_ni, done_o && (status_o != ST_OK), (point_x_o == '0) && (point_y_o == '0))
  `TSGF_ASSERT_IMPLIES(a_queue_never_backs_up, clk_i, rst_ni, 1'b1, fifo_count != 2'd2)
  `TSGF_ASSERT_IMPLIES(a_done_follows_push, clk_i, rst_ni, done_o, $past(push, 4))
  `TSGF_ASSERT_NEXT(a_push_reaches_queue, clk_i, rst_ni, push, !empty)

endmodule

`default_nettype wire

@@ sim/touch_sample_group_filter_unit_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Touch sample group filter unit testbench
// Drives directed and clustered random nine-sample captures, early releases
// and noise through the filter under several reject thresholds, predicts
// every point, scatter reject and release, and checks each strobed result.
// ---------------------------------------------------------------------------

module touch_sample_group_filter_unit_test;
  import tsgf_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_SAMPLE = 4095;

  typedef sample_t axis_set_t [9];

  typedef struct packed {
    status_e status;
    sample_t point_x;
    sample_t point_y;
  } touch_point_t;

  class touch_filter_scoreboard;
    thresh_t          threshold;
    axis_set_t        x_store;
    axis_set_t        y_store;
    int unsigned      fill;
    touch_point_t     pending_points[$];
    int unsigned      errors;

    function new();
      threshold = THRESH_RESET;
      fill = 0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int unsigned spread(input int unsigned a, input int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    function bit filter_axis(input axis_set_t s, output sample_t pt);
      int unsigned m[3];
      int unsigned d01, d12, d20, pair_sum;
      for (int g = 0; g < 3; g++) begin
        m[g] = (int'(s[3*g]) + int'(s[3*g+1]) + int'(s[3*g+2])) / GROUP_LEN;
      end
      d01 = spread(m[0], m[1]);
      d12 = spread(m[1], m[2]);
      d20 = spread(m[2], m[0]);
      pt = '0;
      if (d01 > threshold && d12 > threshold && d20 > threshold) return 1'b0;
      if (d01 < d12) begin
        pair_sum = (d20 < d01) ? m[0] + m[2] : m[0] + m[1];
      end else if (d20 < d12) begin
        pair_sum = m[0] + m[2];
      end else begin
        pair_sum = m[1] + m[2];
      end
      pt = sample_t'(pair_sum / 2);
      return 1'b1;
    endfunction

    function void take_sample(input sample_t sx, input sample_t sy, input logic pen);
      touch_point_t res;
      sample_t px, py;
      x_store[fill] = sx;
      y_store[fill] = sy;
      fill++;
      if (fill == 9) begin
        fill = 0;
        if (filter_axis(x_store, px) && filter_axis(y_store, py)) begin
          res = '{status: ST_OK, point_x: px, point_y: py};
        end else begin
          res = '{status: ST_SCATTER, point_x: '0, point_y: '0};
        end
        pending_points.push_back(res);
      end else if (pen) begin
        fill = 0;
        res = '{status: ST_RELEASE, point_x: '0, point_y: '0};
        pending_points.push_back(res);
      end
    endfunction

    task match_point(input logic [1:0] st, input sample_t px, input sample_t py);
      touch_point_t want;
      if (pending_points.size() == 0) begin
        report($sformatf("result with nothing expected: status %0d x %0d y %0d",
                         st, px, py));
      end else begin
        want = pending_points.pop_front();
        if (st !== want.status)
          report($sformatf("status got %0d expected %0d", st, want.status));
        if (px !== want.point_x)
          report($sformatf("point_x got %0d expected %0d", px, want.point_x));
        if (py !== want.point_y)
          report($sformatf("point_y got %0d expected %0d", py, want.point_y));
      end
    endtask

    task flush_missing();
      touch_point_t want;
      while (pending_points.size() != 0) begin
        want = pending_points.pop_front();
        report($sformatf("missing result: status %0d x %0d y %0d",
                         want.status, want.point_x, want.point_y));
      end
    endtask
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start_i = 1'b0;
  logic    busy_o;
  sample_t sample_x_i = '0;
  sample_t sample_y_i = '0;
  logic    pen_up_i = 1'b0;
  logic    cfg_we_i = 1'b0;
  thresh_t cfg_wdata_i = '0;
  logic    done_o;
  logic [1:0] status_o;
  sample_t point_x_o;
  sample_t point_y_o;

  touch_filter_scoreboard sb;
  int unsigned stalled_cycles = 0;

  touch_sample_group_filter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .sample_x_i  (sample_x_i),
    .sample_y_i  (sample_y_i),
    .pen_up_i    (pen_up_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.threshold = cfg_wdata_i;
      if (start_i && !busy_o) sb.take_sample(sample_x_i, sample_y_i, pen_up_i);
      if (done_o) sb.match_point(status_o, point_x_o, point_y_o);
      if ((start_i && !busy_o) || done_o) stalled_cycles = 0;
      else stalled_cycles++;
    end
  end

  initial begin
    while (stalled_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_sample(input sample_t sx, input sample_t sy, input logic pen,
                             input int unsigned idle_pct);
    start_i    <= 1'b1;
    sample_x_i <= sx;
    sample_y_i <= sy;
    pen_up_i   <= pen;
    do @(posedge clk_i); while (busy_o);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic send_capture(input axis_set_t xs, input axis_set_t ys,
                              input int unsigned len, input logic last_pen,
                              input int unsigned idle_pct);
    for (int i = 0; i < len; i++) begin
      send_sample(xs[i], ys[i], (i == len - 1) ? last_pen : 1'b0, idle_pct);
    end
  endtask

  task automatic hold_until_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input thresh_t value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic sample_t clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > int'(MAX_SAMPLE)) return sample_t'(MAX_SAMPLE);
    return sample_t'(v);
  endfunction

  task automatic make_axis(input int group_spread, output axis_set_t s);
    int centre, group_mean, jitter;
    centre = $urandom_range(0, MAX_SAMPLE);
    jitter = $urandom_range(0, 6);
    for (int g = 0; g < 3; g++) begin
      group_mean = centre + int'($urandom_range(0, 2 * group_spread)) - group_spread;
      for (int i = 0; i < 3; i++) begin
        s[3*g+i] = clamp_sample(group_mean + int'($urandom_range(0, 2 * jitter)) - jitter);
      end
    end
  endtask

  function automatic int pick_spread();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8);
      1: return $urandom_range(0, 200);
      2: return $urandom_range(100, 800);
      default: return $urandom_range(0, MAX_SAMPLE);
    endcase
  endfunction

  task automatic run_random(input int unsigned n_items, input int unsigned idle_pct);
    axis_set_t xs, ys;
    int unsigned sent, len, pick;
    logic last_pen;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        make_axis(pick_spread(), xs);
        make_axis(pick_spread(), ys);
        if ($urandom_range(0, 99) < 15) begin
          len = $urandom_range(1, 8);
          last_pen = 1'b1;
        end else begin
          len = 9;
          last_pen = ($urandom_range(0, 99) < 30);
        end
        send_capture(xs, ys, len, last_pen, idle_pct);
        sent += len;
        if ($urandom_range(0, 99) < 3) hold_until_drained();
      end else begin
        // noise burst, closed by a pen-up so the next capture starts aligned
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_sample(sample_t'($urandom_range(0, MAX_SAMPLE)),
                      sample_t'($urandom_range(0, MAX_SAMPLE)),
                      (i == len - 1) ? 1'b1 : logic'($urandom_range(0, 3) == 0),
                      idle_pct);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    axis_set_t xs, ys;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // release on the first sample of a capture
    send_sample(sample_t'(0), sample_t'(0), 1'b1, 27);
    // release after two samples
    send_sample(sample_t'(MAX_SAMPLE), sample_t'(MAX_SAMPLE), 1'b0, 27);
    send_sample(sample_t'(0), sample_t'(MAX_SAMPLE), 1'b1, 27);
    // full-scale capture, pen up on the ninth sample
    xs = '{default: sample_t'(MAX_SAMPLE)};
    ys = '{default: sample_t'(MAX_SAMPLE)};
    send_capture(xs, ys, 9, 1'b1, 27);
    // widely scattered groups on both axes
    xs = '{12'd0, 12'd0, 12'd0, 12'd2000, 12'd2000, 12'd2000, 12'd4095, 12'd4095, 12'd4095};
    ys = '{12'd4095, 12'd4094, 12'd4093, 12'd100, 12'd101, 12'd102, 12'd2500, 12'd2500, 12'd2501};
    send_capture(xs, ys, 9, 1'b0, 27);
    hold_until_drained();

    run_random(480, 27);
    write_threshold(thresh_t'(0));
    run_random(460, 63);
    write_threshold(thresh_t'(MAX_SAMPLE));
    run_random(460, 0);
    write_threshold(thresh_t'($urandom_range(1, 1000)));
    run_random(480, 0);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.flush_missing();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/tsgf_pkg.sv
hw/rtl/tsgf_front.sv
hw/rtl/tsgf_fifo.sv
hw/rtl/tsgf_back.sv
hw/rtl/touch_sample_group_filter_unit.sv
sim/touch_sample_group_filter_unit_test.sv
